// ===== src/tmt_pkg.sv =====
`timescale 1ns / 1ps

package tmt_pkg;

   // Widths fixed by the converter frame and the result word layout.
   localparam int RawWidth     = 32;
   localparam int ChanWidth    = 2;
   localparam int TempWidth    = 14;
   localparam int FaultWidth   = 3;
   localparam int TempLsb      = 18;
   localparam int TempMsb      = TempLsb + TempWidth - 1;

   localparam logic [FaultWidth-1:0] FaultMask = 3'b111;

   // Packed stream layouts.
   localparam int ReqDataWidth = 40;   // raw_word, channel, zero fill
   localparam int ReqUserWidth = 1;    // clear_history
   localparam int RspDataWidth = 48;   // temperature_q, fault_bits, min_q, max_q, zero fill
   localparam int RspUserWidth = 2;    // fault, history_valid

   typedef logic signed [TempWidth-1:0] temp_type;

   // Decoded frame handed from the decoder to the history tracker.
   typedef struct packed {
      temp_type                temperature;
      logic                    fault;
      logic [FaultWidth-1:0]   fault_bits;
   } sample_type;

   // Channel history as it stands after the current sample.
   typedef struct packed {
      temp_type   min_q;
      temp_type   max_q;
      logic       valid;
   } history_type;

endpackage

// ===== src/tmt_decode.sv =====
`timescale 1ns / 1ps

module tmt_decode
   import tmt_pkg::*;
(
   input  logic [RawWidth-1:0] raw_word,
   output sample_type          sample
);

   logic [FaultWidth-1:0] fbits;

   assign fbits = raw_word[FaultWidth-1:0] & FaultMask;

   always_comb begin
      sample.fault_bits  = fbits;
      sample.fault       = |fbits;
      // The 14-bit field is already two's complement, so taking it as signed
      // is the sign extension.
      sample.temperature = sample.fault ? '0 : temp_type'(raw_word[TempMsb:TempLsb]);
   end

endmodule

// ===== src/tmt_history.sv =====
`timescale 1ns / 1ps

module tmt_history
   import tmt_pkg::*;
#(
   parameter int CHANNELS = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic [ChanWidth-1:0] channel,
   input  logic                 clear_history,
   input  sample_type           sample,
   output history_type          history
);

   localparam int IdxWidth = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   temp_type              min_ff [CHANNELS];
   temp_type              max_ff [CHANNELS];
   logic [CHANNELS-1:0]   seen_ff;
   logic [CHANNELS-1:0]   seen_in;

   logic [IdxWidth-1:0]   idx;
   logic                  in_range;
   logic                  seen_now;
   logic                  wr_en;
   temp_type              cur_min;
   temp_type              cur_max;
   temp_type              new_min;
   temp_type              new_max;

   assign in_range = ({{(32-ChanWidth){1'b0}}, channel} < 32'(CHANNELS));
   assign idx      = IdxWidth'(channel);

   always_comb begin
      cur_min  = '0;
      cur_max  = '0;
      seen_now = 1'b0;
      if (in_range) begin
         cur_min  = min_ff[idx];
         cur_max  = max_ff[idx];
         seen_now = seen_ff[idx] & ~clear_history;
      end
   end

   assign wr_en = in_range & ~sample.fault;

   always_comb begin
      new_min = cur_min;
      new_max = cur_max;
      if (wr_en) begin
         if (!seen_now) begin
            new_min = sample.temperature;
            new_max = sample.temperature;
         end else begin
            if (sample.temperature < cur_min) new_min = sample.temperature;
            if (sample.temperature > cur_max) new_max = sample.temperature;
         end
      end
   end

   always_comb begin
      history.valid = seen_now | wr_en;
      history.min_q = history.valid ? new_min : '0;
      history.max_q = history.valid ? new_max : '0;
   end

   always_comb begin
      seen_in = seen_ff;
      if (item_valid) begin
         if (clear_history) seen_in = '0;
         if (wr_en) seen_in[idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && wr_en) begin
         min_ff[idx] <= new_min;
         max_ff[idx] <= new_max;
      end
   end

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (item_valid && history.valid) |-> (history.min_q <= history.max_q))
      else $error("running minimum above running maximum");

   a_first_sample: assert property (@(posedge clock) disable iff (reset)
      (item_valid && wr_en && !seen_now) |->
         (history.min_q == sample.temperature && history.max_q == sample.temperature))
      else $error("first sample did not seed both extremes");

   a_seen_set: assert property (@(posedge clock) disable iff (reset)
      (item_valid && wr_en) |=> seen_ff[$past(idx)])
      else $error("seen flag not set after a valid sample");

   a_fault_keeps: assert property (@(posedge clock) disable iff (reset)
      (item_valid && sample.fault && !clear_history) |=> (seen_ff == $past(seen_ff)))
      else $error("fault frame changed the history");

endmodule

// ===== src/thermocouple_minmax_tracker_core.sv =====
`timescale 1ns / 1ps
// A word accepted on req passes through the input register and then the result register before it
// is presented on rsp. Throughput: one word per cycle while rsp is not stalled; the per-channel
// min/max read-modify-write is combinational and is written as the word enters the result register.
// Backpressure on rsp stalls both stages; req_tready stays high while the input stage can move.
// Reset (synchronous, active high) empties both stages and clears every channel's seen flag.
// The min/max stores are not reset; they are only read after a valid sample has written them.

module thermocouple_minmax_tracker_core
   import tmt_pkg::*;
#(
   parameter int CHANNELS = 4
)
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // Fields from bit 0: raw_word[31:0], channel[33:32], zero fill [39:34].
   input  logic [ReqDataWidth-1:0] req_tdata,
   // Fields from bit 0: clear_history[0].
   input  logic [ReqUserWidth-1:0] req_tuser,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // Fields from bit 0: temperature_q[13:0], fault_bits[16:14], min_q[30:17],
   // max_q[44:31], zero fill [47:45].
   output logic [RspDataWidth-1:0] rsp_tdata,
   // Fields from bit 0: fault[0], history_valid[1].
   output logic [RspUserWidth-1:0] rsp_tuser
);

   // Input stage: the accepted word waits here until the result register can take it.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [RawWidth-1:0]    raw_ff;
   logic [ChanWidth-1:0]   chan_ff;
   logic                   clear_ff;

   // Result stage.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   sample_type             rsp_sample_ff;
   history_type            rsp_hist_ff;

   logic                   advance;
   logic                   req_take;
   logic                   process;
   sample_type             sample;
   history_type            history;

   // The result register is free when it is empty or is being emptied this cycle.
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;
   assign process    = in_valid_ff & advance;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = process | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff   <= req_tdata[RawWidth-1:0];
         chan_ff  <= req_tdata[RawWidth+ChanWidth-1:RawWidth];
         clear_ff <= req_tuser[0];
      end
   end

   tmt_decode u_decode (
      .raw_word (raw_ff),
      .sample   (sample)
   );

   // The history store is updated in the same cycle the result is captured, so the
   // next word in the input stage already sees this word's effect.
   tmt_history #(
      .CHANNELS (CHANNELS)
   ) u_history (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (process),
      .channel       (chan_ff),
      .clear_history (clear_ff),
      .sample        (sample),
      .history       (history)
   );

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_sample_ff <= sample;
         rsp_hist_ff   <= history;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_hist_ff.max_q,
                        rsp_hist_ff.min_q,
                        rsp_sample_ff.fault_bits,
                        rsp_sample_ff.temperature};
   assign rsp_tuser  = {rsp_hist_ff.valid, rsp_sample_ff.fault};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input stage would be overwritten while stalled");

   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_hist_ff)))
      else $error("stalled result changed");

   a_fell_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_tready))
      else $error("result dropped without a handshake");

endmodule

// ===== tb/thermocouple_minmax_tracker_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the tracker, keeps its own copy of the per-channel
// history and compares every result word with the oldest prediction.
module thermocouple_minmax_tracker_checker
   import tmt_pkg::*;
#(
   parameter int CHANNELS = 4
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic [ReqUserWidth-1:0] req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   input  logic [RspUserWidth-1:0] rsp_tuser,
   output int                      mismatches,
   output int                      pending
);

   typedef struct {
      sample_type  sample;
      history_type history;
   } reading_type;

   temp_type    channel_min [CHANNELS];
   temp_type    channel_max [CHANNELS];
   logic        channel_seen [CHANNELS];
   reading_type expected_readings [$];
   int          mismatch_count = 0;

   assign mismatches = mismatch_count;
   assign pending    = expected_readings.size();

   // Decodes one frame and folds it into the tracked history of its channel.
   function automatic reading_type track_frame(input logic [RawWidth-1:0] raw,
                                               input logic [ChanWidth-1:0] chan,
                                               input logic clear);
      reading_type r;
      r.sample.fault_bits  = raw[FaultWidth-1:0];
      r.sample.fault       = |(raw[FaultWidth-1:0] & FaultMask);
      r.sample.temperature = '0;
      r.history            = '{min_q: '0, max_q: '0, valid: 1'b0};
      if (clear) begin
         for (int i = 0; i < CHANNELS; i++) channel_seen[i] = 1'b0;
      end
      if (!r.sample.fault) r.sample.temperature = temp_type'(raw[TempMsb:TempLsb]);
      if (chan < CHANNELS) begin
         if (!r.sample.fault) begin
            if (!channel_seen[chan]) begin
               channel_min[chan]  = r.sample.temperature;
               channel_max[chan]  = r.sample.temperature;
               channel_seen[chan] = 1'b1;
            end else begin
               if (r.sample.temperature < channel_min[chan])
                  channel_min[chan] = r.sample.temperature;
               if (r.sample.temperature > channel_max[chan])
                  channel_max[chan] = r.sample.temperature;
            end
         end
         r.history.valid = channel_seen[chan];
         if (r.history.valid) begin
            r.history.min_q = channel_min[chan];
            r.history.max_q = channel_max[chan];
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) channel_seen[i] = 1'b0;
         expected_readings.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_readings.push_back(track_frame(req_tdata[RawWidth-1:0],
               req_tdata[RawWidth +: ChanWidth], req_tuser[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("result word arrived with no prediction waiting");
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("temperature_q", int'(want.sample.temperature),
                           int'(temp_type'(rsp_tdata[13:0])));
               check_field("fault", int'(want.sample.fault), int'(rsp_tuser[0]));
               check_field("fault_bits", int'(want.sample.fault_bits),
                           int'(rsp_tdata[16:14]));
               check_field("min_q", int'(want.history.min_q),
                           int'(temp_type'(rsp_tdata[30:17])));
               check_field("max_q", int'(want.history.max_q),
                           int'(temp_type'(rsp_tdata[44:31])));
               check_field("history_valid", int'(want.history.valid),
                           int'(rsp_tuser[1]));
            end
         end
      end
   end

endmodule

// ===== tb/thermocouple_minmax_tracker_core_test.sv =====
`timescale 1ns / 1ps

// Top of the tracker test. It produces the clock and the single reset, sends
// converter frames on the request stream, throttles the result stream, and
// gives the verdict from what the checker reports.
module thermocouple_minmax_tracker_core_test;
   import tmt_pkg::*;

   localparam int RandomWords = 850;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 200;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic [ReqUserWidth-1:0] req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [RspUserWidth-1:0] rsp_tuser;
   int                      mismatches;
   int                      pending;

   int   cycle_count    = 0;
   logic send_steady    = 1'b0;
   logic hold_requested = 1'b0;

   thermocouple_minmax_tracker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   thermocouple_minmax_tracker_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run is cut off if the streams ever lock up.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Idle length for either side: mostly none or a few cycles, now and then
   // a long pause.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Builds a clean frame carrying a temperature in quarter degrees.
   function automatic logic [RawWidth-1:0] temp_frame(input int quarter_degrees);
      logic [TempWidth-1:0] code;
      code = quarter_degrees[TempWidth-1:0];
      return {code, {TempLsb{1'b0}}};
   endfunction

   // Offers one word and returns at the falling edge after it was taken.
   // An idle gap, if any, is placed before the word so that tvalid is never
   // dropped and raised within the same time step.
   task automatic send_frame(input logic [RawWidth-1:0] raw,
                             input logic [ChanWidth-1:0] chan,
                             input logic clear);
      int gap;
      gap = send_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - RawWidth - ChanWidth){1'b0}}, chan, raw};
      req_tuser  <= clear;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side. Once the random phase begins, the receiver refuses words
   // for a long stretch so that both pipeline stages fill and req_tready
   // drops while the sender keeps offering. After that it stalls at random,
   // with steady stretches mixed in.
   initial begin
      int   stall_left;
      logic recv_steady;
      logic hold_done;
      stall_left  = 0;
      recv_steady = 1'b1;
      hold_done   = 1'b0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count % 64 == 0) recv_steady = ($urandom_range(0, 2) == 0);
         if (hold_requested && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!recv_steady && $urandom_range(0, 4) == 0) stall_left = idle_gap();
         end
      end
   end

   // Request side and verdict.
   initial begin
      logic [RawWidth-1:0]  raw;
      logic [ChanWidth-1:0] chan;
      logic                 clear;
      int                   pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words. The first one clears history and starts channel 0
      // at zero; then the temperature extremes go in on the same channel.
      send_steady = 1'b1;
      send_frame(temp_frame(0), 2'd0, 1'b1);
      send_frame(temp_frame(8191), 2'd0, 1'b0);
      send_frame(temp_frame(-8192), 2'd0, 1'b0);
      send_frame(temp_frame(-1), 2'd0, 1'b0);
      // Fault frames on a channel that has no history yet, each fault bit
      // alone, all three together, and a frame of all ones.
      send_frame(temp_frame(300) | 32'h1, 2'd1, 1'b0);
      send_frame(temp_frame(-300) | 32'h2, 2'd1, 1'b0);
      send_frame(temp_frame(8191) | 32'h4, 2'd1, 1'b0);
      send_frame(32'h0000_0007, 2'd1, 1'b0);
      send_frame(32'hFFFF_FFFF, 2'd1, 1'b0);
      // First valid sample of channel 1, then a negative frame whose unused
      // middle bits are all set.
      send_frame(temp_frame(100), 2'd1, 1'b0);
      send_frame(32'hFFFF_FFF8, 2'd1, 1'b0);
      send_frame(temp_frame(5), 2'd2, 1'b0);
      send_frame(temp_frame(-5), 2'd3, 1'b0);
      send_frame(temp_frame(7), 2'd3, 1'b0);
      // A fault on a channel with history leaves its minimum and maximum.
      send_frame(temp_frame(1000) | 32'h1, 2'd0, 1'b0);
      // A clear carried by a fault frame leaves every channel empty.
      send_frame(temp_frame(20) | 32'h4, 2'd2, 1'b1);
      send_frame(32'h0000_0003, 2'd0, 1'b0);
      // A clear carried by a valid frame restarts its channel at once.
      send_frame(temp_frame(-4000), 2'd3, 1'b1);
      send_frame(temp_frame(4000), 2'd3, 1'b0);
      send_frame(temp_frame(8191), 2'd2, 1'b0);
      send_frame(temp_frame(-8192), 2'd2, 1'b0);

      // Random words: mostly clean frames with random temperatures and
      // random unused bits, some fault frames, some words of pure noise,
      // and a clear now and then so that history keeps restarting.
      hold_requested = 1'b1;
      for (int n = 0; n < RandomWords; n++) begin
         if (n % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         raw  = $urandom;
         if (pick < 75) begin
            raw[FaultWidth-1:0] = '0;
         end else if (pick < 90) begin
            raw[FaultWidth-1:0] = FaultWidth'($urandom_range(1, 7));
         end
         chan  = ChanWidth'($urandom_range(0, 3));
         clear = ($urandom_range(0, 99) < 3);
         send_frame(raw, chan, clear);
      end
      req_tvalid <= 1'b0;

      // Let every predicted word come back, then allow a few more cycles
      // for anything unexpected to show up.
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tmt_pkg.sv
src/tmt_decode.sv
src/tmt_history.sv
src/thermocouple_minmax_tracker_core.sv
tb/thermocouple_minmax_tracker_checker.sv
tb/thermocouple_minmax_tracker_core_test.sv
